>>> rtl/mtpa_pkg.sv
// Shared widths, register indexes and the configuration bundle for the MTPA d-axis reference.
package mtpa_pkg;

    localparam int WORD_W   = 32;   // q current and d reference
    localparam int CFG_W    = 31;   // flux and inductances
    localparam int IDX_W    = 2;    // configuration register index
    localparam int PROD_W   = 62;   // |Lq-Ld| * |iq|
    localparam int HALF_W   = 31;   // half of a product for the squaring split
    localparam int SQ_W     = 124;  // product squared
    localparam int RAD_W    = 128;  // radicand
    localparam int ROOT_W   = 64;   // square root
    localparam int REM_W    = 66;   // root remainder and wide compares
    localparam int DIV_W    = 33;   // 4*|Lq-Ld|
    localparam int QUO_W    = 33;   // low quotient bits
    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 33;

    typedef enum logic [IDX_W-1:0] {
        REG_FLUX = 2'd0,
        REG_LD   = 2'd1,
        REG_LQ   = 2'd2
    } cfg_index_t;

    // Pipeline configuration; the user keeps it stable while items are in flight, not the block
    typedef struct packed {
        logic [CFG_W-1:0]   flux;
        logic [PROD_W-1:0]  flux_sq;
        logic [CFG_W-1:0]   dmag;
        logic [DIV_W-1:0]   dmag4;
        logic               lq_greater;
        logic               equal;
    } cfg_t;

endpackage

>>> rtl/mtpa_d_current_reference.sv
// Top level: configuration registers and the MTPA d-axis reference pipeline.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_q_current
//   m_        out        m_valid/m_ready    m_d_current_ref, m_saturated, m_equal_inductance
//   cfg_wr_   in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// One item per cycle unless m_ready stalls the output; the path has four radicand stages,
// 64 square-root stages (one root bit each), two numerator stages, 33 divide stages and
// the output register. Synchronous reset clears all valid bits and the configuration
// registers. A stall on m_ready freezes every stage at once, and s_ready drops with it.
module mtpa_d_current_reference (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mtpa_pkg::IDX_W-1:0]         cfg_wr_index,
    input  logic [mtpa_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mtpa_pkg::WORD_W-1:0] s_q_current,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mtpa_pkg::WORD_W-1:0] m_d_current_ref,
    output logic                               m_saturated,
    output logic                               m_equal_inductance
);
    import mtpa_pkg::*;

    logic [CFG_W-1:0]  flux_reg, ld_reg, lq_reg;
    logic [PROD_W-1:0] flux_sq_reg;
    logic              adv;
    cfg_t              cfg;
    logic              rad_valid, root_valid;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [WORD_W-1:0] id;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flux_reg <= '0;
            ld_reg   <= '0;
            lq_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_FLUX: flux_reg <= cfg_wr_data;
                REG_LD:   ld_reg   <= cfg_wr_data;
                REG_LQ:   lq_reg   <= cfg_wr_data;
                default:  ;
            endcase
        end
    end

    // Square the flux ahead of its first use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flux_sq_reg <= '0;
        end else begin
            flux_sq_reg <= PROD_W'(flux_reg) * PROD_W'(flux_reg);
        end
    end

    // Derive the inductance difference
    always_comb begin
        cfg.flux       = flux_reg;
        cfg.flux_sq    = flux_sq_reg;
        cfg.lq_greater = lq_reg > ld_reg;
        cfg.dmag       = cfg.lq_greater ? (lq_reg - ld_reg) : (ld_reg - lq_reg);
        cfg.dmag4      = {cfg.dmag, 2'b00};
        cfg.equal      = lq_reg == ld_reg;
    end

    // Advance the whole pipeline unless the output item is stalled
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    mtpa_radicand u_radicand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_q      (s_q_current),
        .out_valid (rad_valid),
        .out_rad   (rad)
    );

    mtpa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rad_valid),
        .in_rad    (rad),
        .out_valid (root_valid),
        .out_root  (root)
    );

    mtpa_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (root_valid),
        .in_root   (root),
        .out_valid (m_valid),
        .out_id    (id),
        .out_sat   (m_saturated),
        .out_equal (m_equal_inductance)
    );

    assign m_d_current_ref = id;

endmodule

>>> rtl/mtpa_radicand.sv
// Front stages: build the radicand flux^2 * 2^62 + 8 * (|Lq-Ld| * |iq|)^2 over four stages.
module mtpa_radicand (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  mtpa_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    input  logic [mtpa_pkg::WORD_W-1:0] in_q,
    output logic                        out_valid,
    output logic [mtpa_pkg::RAD_W-1:0]  out_rad
);
    import mtpa_pkg::*;

    logic [WORD_W-1:0]   qmag;
    logic [PROD_W:0]     prod_full;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   hh_reg, hl_reg, ll_reg;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [3:0]          v_reg;
    logic [HALF_W-1:0]   ph, pl;

    // Magnitude of the command; the most negative code maps to 2^31
    assign qmag      = in_q[WORD_W-1] ? (~in_q + 1'b1) : in_q;
    assign prod_full = (PROD_W+1)'(cfg.dmag) * (PROD_W+1)'(qmag);
    assign ph        = prod_reg[PROD_W-1:HALF_W];
    assign pl        = prod_reg[HALF_W-1:0];

    // Recombine the partial products
    assign sq_next  = {hh_reg, 62'b0} + SQ_W'({hl_reg, 32'b0}) + SQ_W'(ll_reg);
    assign rad_next = {4'b0, cfg.flux_sq, 62'b0} + {1'b0, sq_reg, 3'b0};

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_full[PROD_W-1:0];
            hh_reg   <= PROD_W'(ph) * PROD_W'(ph);
            hl_reg   <= PROD_W'(ph) * PROD_W'(pl);
            ll_reg   <= PROD_W'(pl) * PROD_W'(pl);
            sq_reg   <= sq_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_rad   = rad_reg;

endmodule

>>> rtl/mtpa_sqrt.sv
// Restoring square root, one root bit per pipeline stage.
module mtpa_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [mtpa_pkg::RAD_W-1:0]   in_rad,
    output logic                         out_valid,
    output logic [mtpa_pkg::ROOT_W-1:0]  out_root
);
    import mtpa_pkg::*;

    logic [REM_W-1:0]  r_q [0:SQRT_STEPS];
    logic [ROOT_W-1:0] q_q [0:SQRT_STEPS];
    logic [RAD_W-1:0]  x_q [0:SQRT_STEPS];
    logic              v_q [0:SQRT_STEPS];

    assign r_q[0] = '0;
    assign q_q[0] = '0;
    assign x_q[0] = in_rad;
    assign v_q[0] = in_valid;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        logic [REM_W-1:0]  r_sh, t, r_reg, r_next;
        logic [ROOT_W-1:0] q_reg, q_next;
        logic [RAD_W-1:0]  x_reg;
        logic              v_reg, ge;

        // Bring down two radicand bits and try the next root bit
        assign r_sh   = {r_q[i][63:0], x_q[i][RAD_W-1:RAD_W-2]};
        assign t      = {1'b0, q_q[i][62:0], 2'b01};
        assign ge     = r_sh >= t;
        assign r_next = ge ? (r_sh - t) : r_sh;
        assign q_next = {q_q[i][62:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= v_q[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg <= r_next;
                q_reg <= q_next;
                x_reg <= {x_q[i][RAD_W-3:0], 2'b00};
            end
        end

        assign r_q[i+1] = r_reg;
        assign q_q[i+1] = q_reg;
        assign x_q[i+1] = x_reg;
        assign v_q[i+1] = v_reg;
    end

    assign out_valid = v_q[SQRT_STEPS];
    assign out_root  = q_q[SQRT_STEPS];

endmodule

>>> rtl/mtpa_divide.sv
// Numerator, restoring division by 4*|Lq-Ld| one bit per stage, sign and saturation.
module mtpa_divide (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  mtpa_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  logic [mtpa_pkg::ROOT_W-1:0]  in_root,
    output logic                         out_valid,
    output logic [mtpa_pkg::WORD_W-1:0]  out_id,
    output logic                         out_sat,
    output logic                         out_equal
);
    import mtpa_pkg::*;

    logic [ROOT_W-1:0] num_reg, rem0_reg;
    logic              va_reg, vb_reg, hi_reg;
    logic [ROOT_W-1:0] rem_q [0:DIV_STEPS];
    logic [QUO_W-1:0]  quo_q [0:DIV_STEPS];
    logic              hi_q  [0:DIV_STEPS];
    logic              v_q   [0:DIV_STEPS];
    logic [QUO_W-1:0]  mag;
    logic              sat_next;
    logic [WORD_W-1:0] id_next;
    logic              v_out_reg, sat_reg, eq_reg;
    logic [WORD_W-1:0] id_reg;

    // Subtract the flux term, then test for a quotient of 2^33 or more
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg  <= in_root - {2'b0, cfg.flux, 31'b0};
            hi_reg   <= {2'b0, num_reg} >= {cfg.dmag4, 33'b0};
            rem0_reg <= num_reg;
        end
    end

    assign rem_q[0] = rem0_reg;
    assign quo_q[0] = '0;
    assign hi_q[0]  = hi_reg;
    assign v_q[0]   = vb_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        localparam int K = DIV_STEPS - 1 - i;
        logic [REM_W-1:0]  dsh, rem_w;
        logic              ge, v_reg, hi_st_reg;
        logic [ROOT_W-1:0] rem_reg;
        logic [QUO_W-1:0]  quo_reg;

        // Try quotient bit K
        assign dsh   = REM_W'(cfg.dmag4) << K;
        assign rem_w = {2'b0, rem_q[i]};
        assign ge    = rem_w >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= v_q[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg   <= ge ? ROOT_W'(rem_w - dsh) : rem_q[i];
                quo_reg   <= {quo_q[i][QUO_W-2:0], ge};
                hi_st_reg <= hi_q[i];
            end
        end

        assign rem_q[i+1] = rem_reg;
        assign quo_q[i+1] = quo_reg;
        assign hi_q[i+1]  = hi_st_reg;
        assign v_q[i+1]   = v_reg;
    end

    // Apply sign, clip to Q1.31 and force zero for equal inductances
    assign mag = quo_q[DIV_STEPS];
    always_comb begin
        if (cfg.equal) begin
            sat_next = 1'b0;
            id_next  = '0;
        end else if (cfg.lq_greater) begin
            sat_next = hi_q[DIV_STEPS] || (mag > 33'h080000000);
            id_next  = sat_next ? 32'h80000000 : (~mag[WORD_W-1:0] + 1'b1);
        end else begin
            sat_next = hi_q[DIV_STEPS] || mag[32] || mag[31];
            id_next  = sat_next ? 32'h7FFFFFFF : mag[WORD_W-1:0];
        end
    end

    // Hold the result in the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (adv) begin
            v_out_reg <= v_q[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            id_reg  <= id_next;
            sat_reg <= sat_next;
            eq_reg  <= cfg.equal;
        end
    end

    assign out_valid = v_out_reg;
    assign out_id    = id_reg;
    assign out_sat   = sat_reg;
    assign out_equal = eq_reg;

endmodule
